/* hdl/apt_pkg.sv */
// Package for the affine point transform: beat types, sizes and codes.
package apt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_SLOTS     = 12;
	localparam int NUM_ROWS      = 3;
	localparam int COEF_W        = 32;
	localparam int PROD_W        = 2 * COEF_W;
	localparam int SUM_W         = PROD_W + 2;
	localparam int OUT_DEPTH     = 8;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_POINT = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [3:0]         coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} req_beat_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               saturated;
	} rsp_beat_t;

	typedef logic [3:0][COEF_W-1:0] row_coef_t;

endpackage

/* hdl/apt_lane.sv */
// One row lane: three products, floor shift, and an exact four-term sum.
module apt_lane import apt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en_s0,
	input  logic                    en_s1,
	input  logic                    en_s2,
	input  logic signed [31:0]      x,
	input  logic signed [31:0]      y,
	input  logic signed [31:0]      z,
	input  row_coef_t               coef,
	output logic signed [SUM_W-1:0] sum_s3
);

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [COEF_W-1:0] tr_s1;
	logic signed [SUM_W-1:0]  ta, tb, tc, td;
	logic signed [SUM_W-1:0]  ab_s2, cd_s2;

	always_ff @(posedge clk) begin
		if (en_s0) begin
			px_s1 <= x * $signed(coef[0]);
			py_s1 <= y * $signed(coef[1]);
			pz_s1 <= z * $signed(coef[2]);
			tr_s1 <= $signed(coef[3]);
		end
	end

	// Arithmetic shift rounds each product toward minus infinity.
	always_comb begin
		ta = SUM_W'(px_s1 >>> FRAC_BITS);
		tb = SUM_W'(py_s1 >>> FRAC_BITS);
		tc = SUM_W'(pz_s1 >>> FRAC_BITS);
		td = SUM_W'(tr_s1);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ab_s2 <= ta + tb;
			cd_s2 <= tc + td;
		end
		if (en_s2) begin
			sum_s3 <= ab_s2 + cd_s2;
		end
	end

endmodule

/* hdl/apt_merge.sv */
// Merging stage: clamps the lane sums, combines the flags and queues result beats.
module apt_merge import apt_pkg::*; (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_s3,
	input  logic [NUM_ROWS-1:0][SUM_W-1:0]    sums_s3,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output rsp_beat_t                         rsp
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd2147483648);

	logic signed [31:0]  clamped [NUM_ROWS];
	logic [NUM_ROWS-1:0] clip;
	rsp_beat_t           beat;
	rsp_beat_t           fifo_q [OUT_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]      cnt_q;
	logic                pop;

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			if ($signed(sums_s3[r]) > SAT_HI) begin
				clamped[r] = 32'sh7fffffff;
				clip[r]    = 1'b1;
			end else if ($signed(sums_s3[r]) < SAT_LO) begin
				clamped[r] = 32'sh80000000;
				clip[r]    = 1'b1;
			end else begin
				clamped[r] = $signed(sums_s3[r][31:0]);
				clip[r]    = 1'b0;
			end
		end
		beat.out_x     = clamped[0];
		beat.out_y     = clamped[1];
		beat.out_z     = clamped[2];
		beat.saturated = |clip;
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			fifo_q[wr_ptr_q] <= beat;
		end
	end

	assign pop       = rsp_valid && !rsp_stall;
	assign rsp_valid = (cnt_q != '0);
	assign rsp       = fifo_q[rd_ptr_q];

	// The top level grants entry only while a slot is free, so no overflow check here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (vld_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(vld_s3) - (PTR_W+1)'(pop);
		end
	end

endmodule

/* hdl/affine_point_transform_top.sv */
// Top level of the affine point transform: coefficient store, three row lanes, merge.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------
//   request | req_valid | req_stall | req (req_beat_t)
//   result  | rsp_valid | rsp_stall | rsp (rsp_beat_t)
//
// One beat is taken each cycle while req_stall is low; a point beat passes through the multiply,
// two adder stages and the clamp into the result queue before it can leave.
// Load beats take effect at once and are seen by the very next point beat.
// Reset sets the matrix to identity with zero translation and empties the queue.
// req_stall rises only when all result queue slots are claimed by beats in flight or
// waiting, so a stalled result side does not freeze the lanes.
module affine_point_transform_top import apt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int CNT_W = $clog2(OUT_DEPTH) + 1;
	localparam logic [COEF_W-1:0] ONE = COEF_W'(64'd1 << FRAC_BITS);

	logic [NUM_SLOTS-1:0][COEF_W-1:0] coef_q;
	logic [NUM_ROWS-1:0][SUM_W-1:0]   sums_s3;
	logic                             take, point_take, load_take;
	logic                             vld_s1, vld_s2, vld_s3;
	logic [CNT_W-1:0]                 credit_q;
	logic                             rsp_take;

	// Identity in the linear part, zero translation.
	function automatic logic [NUM_SLOTS-1:0][COEF_W-1:0] identity_coefs();
		logic [NUM_SLOTS-1:0][COEF_W-1:0] m;
		m     = '0;
		m[0]  = ONE;
		m[5]  = ONE;
		m[10] = ONE;
		return m;
	endfunction

	assign take       = req_valid && !req_stall;
	assign point_take = take && (req.req_type == REQ_POINT);
	assign load_take  = take && (req.req_type == REQ_LOAD);
	assign rsp_take   = rsp_valid && !rsp_stall;
	assign req_stall  = (credit_q == CNT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= identity_coefs();
		end else if (load_take && (req.coef_index < 4'(NUM_SLOTS))) begin
			coef_q[req.coef_index] <= req.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			credit_q <= '0;
		end else begin
			vld_s1   <= point_take;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			credit_q <= credit_q + CNT_W'(point_take) - CNT_W'(rsp_take);
		end
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
		apt_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.en_s0  (point_take),
			.en_s1  (vld_s1),
			.en_s2  (vld_s2),
			.x      (req.point_x),
			.y      (req.point_y),
			.z      (req.point_z),
			.coef   (coef_q[r*4 +: 4]),
			.sum_s3 (sums_s3[r])
		);
	end

	apt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s3    (vld_s3),
		.sums_s3   (sums_s3),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
